>>> design/wud_pkg.sv
package wud_pkg;

   // Field widths of the stream payloads
   localparam int WUD_LO_BITS    = 64;
   localparam int WUD_HI_BITS    = 32;
   localparam int WUD_FIELD_BITS = WUD_LO_BITS + WUD_HI_BITS;
   localparam int WUD_REQ_BITS   = 2 * WUD_FIELD_BITS;
   localparam int WUD_RSP_BITS   = WUD_FIELD_BITS;

   // Default width of the arithmetic word (range 8..128)
   localparam int WUD_WORD_BITS  = 96;

   // Sequencer states of the divider core
   typedef enum logic [1:0] {
      WUD_IDLE,
      WUD_RUN,
      WUD_DONE
   } wud_state_type;

   // Status from the core to the stream wrapper
   typedef struct packed {
      logic idle;
      logic done;
      logic div_zero;
   } wud_stat_type;

endpackage

>>> design/wud_div_core.sv
module wud_div_core #(
   parameter int WordBits = wud_pkg::WUD_WORD_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 ack,
   input  logic [WordBits-1:0]  dividend,
   input  logic [WordBits-1:0]  divisor,
   output logic [WordBits-1:0]  quotient,
   output wud_pkg::wud_stat_type stat
);
   import wud_pkg::*;

   localparam int CntBits = $clog2(WordBits);
   localparam logic [CntBits-1:0] CntLast = CntBits'(WordBits - 1);

   wud_state_type       state_ff, state_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic [WordBits-1:0] rem_ff, rem_in;
   logic [WordBits-1:0] num_ff, num_in;
   logic [WordBits-1:0] den_ff, den_in;
   logic                dbz_ff, dbz_in;

   logic                divisor_zero;
   logic [WordBits:0]   rem_shift;
   logic [WordBits:0]   diff;
   logic                take;

   assign divisor_zero = (divisor == '0);

   // Shared subtractor: shifted partial remainder minus divisor
   assign rem_shift = {rem_ff, num_ff[WordBits-1]};
   assign diff      = rem_shift - {1'b0, den_ff};
   assign take      = ~diff[WordBits];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         WUD_IDLE: begin
            if (start) begin
               state_in = divisor_zero ? WUD_DONE : WUD_RUN;
            end
         end
         WUD_RUN: begin
            if (cnt_ff == '0) begin
               state_in = WUD_DONE;
            end
         end
         WUD_DONE: begin
            if (ack) begin
               state_in = WUD_IDLE;
            end
         end
         default: state_in = WUD_IDLE;
      endcase
   end

   // Status outputs
   always_comb begin
      stat          = '0;
      stat.div_zero = dbz_ff;
      case (state_ff)
         WUD_IDLE: stat.idle = 1'b1;
         WUD_DONE: stat.done = 1'b1;
         default:  stat      = '{idle: 1'b0, done: 1'b0, div_zero: dbz_ff};
      endcase
   end

   assign quotient = num_ff;

   // Datapath: dividend bits shift out the top, quotient bits shift in the bottom
   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      num_in = num_ff;
      den_in = den_ff;
      dbz_in = dbz_ff;
      if (start && state_ff == WUD_IDLE) begin
         cnt_in = CntLast;
         rem_in = '0;
         num_in = divisor_zero ? '0 : dividend;
         den_in = divisor;
         dbz_in = divisor_zero;
      end else if (state_ff == WUD_RUN) begin
         cnt_in = cnt_ff - 1'b1;
         rem_in = take ? diff[WordBits-1:0] : rem_shift[WordBits-1:0];
         num_in = {num_ff[WordBits-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WUD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
      dbz_ff <= dbz_in;
   end

   // Checks
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == WUD_IDLE)
      else $error("divider started while not idle");

   a_ack_done: assert property (@(posedge clock) disable iff (reset)
      ack |-> state_ff == WUD_DONE)
      else $error("result taken while not done");

   a_run_entry: assert property (@(posedge clock) disable iff (reset)
      (start && !divisor_zero) |=> (state_ff == WUD_RUN && cnt_ff == CntLast))
      else $error("run did not begin with full count");

   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == WUD_DONE && dbz_ff) |-> num_ff == '0)
      else $error("zero divisor gave nonzero quotient");

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      state_ff == WUD_RUN |-> rem_ff < den_ff)
      else $error("partial remainder not below divisor");

endmodule

>>> design/wide_unsigned_divider.sv
// Channel | Ports                            | Payload
// --------+----------------------------------+------------------------------------------
// request | req_tvalid req_tready req_tdata  | dividend_lo, dividend_hi, divisor_lo, divisor_hi
// result  | rsp_tvalid rsp_tready rsp_tdata  | quotient_lo, quotient_hi; tuser: divide_by_zero
//
// One quotient bit per cycle from the shared subtractor; a result goes from the run
// state to the done state, then to the output register (a zero divisor skips run).
// req_tready is high only while the core is idle; one division is in flight at a time,
// so a new request is taken only once the last result is in the output register.
// A result held by a stalled rsp_tready lets the core hold its finished quotient.
// Synchronous active-high reset clears the sequencer and the output valid.
module wide_unsigned_divider #(
   parameter int WordBits = wud_pkg::WUD_WORD_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // dividend_lo [63:0], dividend_hi [95:64], divisor_lo [159:96], divisor_hi [191:160]
   input  logic [wud_pkg::WUD_REQ_BITS-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // quotient_lo [63:0], quotient_hi [95:64]
   output logic [wud_pkg::WUD_RSP_BITS-1:0] rsp_tdata,
   // divide_by_zero [0]
   output logic                             rsp_tuser
);
   import wud_pkg::*;

   localparam int WideBits = (WordBits > WUD_FIELD_BITS) ? WordBits : WUD_FIELD_BITS;

   logic [WideBits-1:0]       dividend_wide, divisor_wide, quotient_wide;
   logic [WordBits-1:0]       quotient;
   wud_stat_type              stat;
   logic                      start, ack;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [WUD_RSP_BITS-1:0]   rsp_data_ff, rsp_data_in;
   logic                      rsp_dbz_ff, rsp_dbz_in;

   // Operands cut or zero-extended to the word width
   assign dividend_wide = WideBits'(req_tdata[WUD_FIELD_BITS-1:0]);
   assign divisor_wide  = WideBits'(req_tdata[WUD_REQ_BITS-1:WUD_FIELD_BITS]);

   assign req_tready = stat.idle;
   assign start      = req_tvalid & stat.idle;
   assign ack        = stat.done & (~rsp_valid_ff | rsp_tready);

   wud_div_core #(
      .WordBits (WordBits)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .ack      (ack),
      .dividend (dividend_wide[WordBits-1:0]),
      .divisor  (divisor_wide[WordBits-1:0]),
      .quotient (quotient),
      .stat     (stat)
   );

   assign quotient_wide = WideBits'(quotient);

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_dbz_in   = rsp_dbz_ff;
      if (ack) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = quotient_wide[WUD_RSP_BITS-1:0];
         rsp_dbz_in   = stat.div_zero;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_dbz_ff  <= rsp_dbz_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_dbz_ff;

endmodule

>>> bench/tb_wide_unsigned_divider.sv
`timescale 1ns / 100ps

module tb_wide_unsigned_divider;

   import wud_pkg::*;

   localparam int WORD_BITS    = WUD_WORD_BITS;
   localparam int FIELD_BITS   = WUD_FIELD_BITS;
   localparam int RANDOM_ITEMS = 1350;
   localparam int STALL_LIMIT  = 2000;
   localparam int GAP_MAX      = 110;

   typedef logic [FIELD_BITS-1:0] word_type;

   // One expected response of the divider
   typedef struct {
      word_type quotient;
      logic     div_zero;
   } quotient_result_type;

   // Predicts quotients and checks responses in arrival order
   class quotient_board;
      quotient_result_type pending_quotients[$];
      int                  errors;

      // Restoring division, one quotient bit per step from the top
      function quotient_result_type predict_quotient(word_type dividend, word_type divisor);
         quotient_result_type res;
         logic [127:0]        num;
         logic [127:0]        den;
         logic [128:0]        rem;
         logic [127:0]        quo;
         int                  n;
         n = WORD_BITS;
         if (n < 1) n = 1;
         if (n > 128) n = 128;
         num = 128'(dividend);
         den = 128'(divisor);
         if (n < 128) begin
            num &= (128'(1) << n) - 128'(1);
            den &= (128'(1) << n) - 128'(1);
         end
         quo = '0;
         rem = '0;
         if (den == '0) begin
            res.quotient = '0;
            res.div_zero = 1'b1;
            return res;
         end
         for (int i = n - 1; i >= 0; i--) begin
            rem = {rem[127:0], num[i]};
            if (rem >= {1'b0, den}) begin
               rem = rem - {1'b0, den};
               quo[i] = 1'b1;
            end
         end
         res.quotient = quo[FIELD_BITS-1:0];
         res.div_zero = 1'b0;
         return res;
      endfunction

      function void note_request(word_type dividend, word_type divisor);
         pending_quotients.push_back(predict_quotient(dividend, divisor));
      endfunction

      function void check_result(word_type quotient, logic div_zero);
         quotient_result_type exp_res;
         if (pending_quotients.size() == 0) begin
            errors++;
            $display("%0t: unexpected response: expected none, actual quotient %h flag %b",
                     $time, quotient, div_zero);
            return;
         end
         exp_res = pending_quotients.pop_front();
         if (quotient[63:0] !== exp_res.quotient[63:0]) begin
            errors++;
            $display("%0t: quotient_lo mismatch: expected %h, actual %h",
                     $time, exp_res.quotient[63:0], quotient[63:0]);
         end
         if (quotient[95:64] !== exp_res.quotient[95:64]) begin
            errors++;
            $display("%0t: quotient_hi mismatch: expected %h, actual %h",
                     $time, exp_res.quotient[95:64], quotient[95:64]);
         end
         if (div_zero !== exp_res.div_zero) begin
            errors++;
            $display("%0t: divide_by_zero mismatch: expected %b, actual %b",
                     $time, exp_res.div_zero, div_zero);
         end
      endfunction

      function int pending();
         return pending_quotients.size();
      endfunction
   endclass

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   // dividend_lo, dividend_hi, divisor_lo, divisor_hi
   logic [WUD_REQ_BITS-1:0] req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // quotient_lo, quotient_hi
   logic [WUD_RSP_BITS-1:0] rsp_tdata;
   // divide_by_zero
   logic                    rsp_tuser;

   logic                    calm = 1'b0;
   int                      idle_cycles = 0;
   quotient_board           board;

   wide_unsigned_divider u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Result side backpressure, off during the calm stretch
   always @(posedge clock) begin
      rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic word_type rand_word();
      return {$urandom, $urandom, $urandom};
   endfunction

   // Random value limited to a given number of significant bits
   function automatic word_type rand_bits(int unsigned nbits);
      return rand_word() >> (FIELD_BITS - nbits);
   endfunction

   // One request transfer, with an occasional gap before it
   task automatic send_divide(word_type dividend, word_type divisor);
      if (!calm && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, GAP_MAX)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {divisor, dividend};
      do @(posedge clock); while (!req_tready);
      board.note_request(dividend, divisor);
   endtask

   task automatic send_random_divide();
      word_type    dividend;
      word_type    divisor;
      int unsigned pick;
      pick     = $urandom_range(99);
      dividend = rand_word();
      if (pick < 4) begin
         divisor = '0;
      end else if (pick < 30) begin
         divisor = rand_word();
      end else if (pick < 55) begin
         // small divisor, long quotient
         divisor = rand_bits($urandom_range(1, 32));
      end else if (pick < 75) begin
         dividend = rand_bits($urandom_range(1, FIELD_BITS));
         divisor  = rand_bits($urandom_range(1, FIELD_BITS));
      end else if (pick < 90) begin
         // divisor close to the dividend
         if ($urandom_range(1))
            divisor = dividend - word_type'($urandom_range(3));
         else
            divisor = dividend + word_type'($urandom_range(3));
      end else begin
         divisor = word_type'(1) << $urandom_range(FIELD_BITS - 1);
      end
      send_divide(dividend, divisor);
   endtask

   initial begin
      word_type all_ones;
      board    = new();
      all_ones = '1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero cases, field extremes, word boundaries
      send_divide('0, '0);
      send_divide(all_ones, '0);
      send_divide('0, all_ones);
      send_divide('0, word_type'(1));
      send_divide(all_ones, word_type'(1));
      send_divide(all_ones, all_ones);
      send_divide(all_ones - 1, all_ones);
      send_divide(all_ones, all_ones - 1);
      send_divide(word_type'(1), all_ones);
      send_divide(all_ones, word_type'(2));
      send_divide(all_ones, word_type'(1) << 95);
      send_divide(word_type'(1) << 95, word_type'(3));
      send_divide({32'hffff_ffff, 64'h0}, {32'h1, 64'h0});
      send_divide({32'h0, 64'hffff_ffff_ffff_ffff}, {32'h0, 64'h1});
      send_divide({32'h1, 64'h0}, {32'h0, 64'hffff_ffff_ffff_ffff});
      send_divide({32'h8000_0000, 64'h0}, {32'h0, 64'h8000_0000_0000_0000});
      send_divide(word_type'(7), word_type'(7));
      send_divide(word_type'(6), word_type'(7));
      send_divide(word_type'(1000), word_type'(10));
      send_divide({32'h1234_5678, 64'h9abc_def0_1357_9bdf},
                  {32'h0, 64'h0000_0000_0000_000a});

      // Random part, with a stretch free of idling on both sides
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == 500) calm <= 1'b1;
         if (k == 800) calm <= 1'b0;
         send_random_divide();
      end
      req_tvalid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (WORD_BITS + 10) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
